>>> rtl/tgi_pkg.sv
// shared types, widths and codes of the trilinear grid interpolator
package tgi_pkg;

    localparam int NUM_CH       = 6;
    localparam int CH_W         = 16;
    localparam int COORD_W      = 18;
    localparam int IDX_W        = 15;
    localparam int CFG_W        = 6;
    localparam int FRAC_W       = 17;
    localparam int Q_SHIFT      = 16;
    localparam int PROD_W       = 18;
    localparam int WGT_W        = 17;
    localparam int ACC_W        = 36;
    localparam int CNT_W        = 4;
    localparam int MAX_GRID_DEF = 32;
    localparam int MIN_GRID     = 2;

    localparam logic [CFG_W-1:0]  CFG_RESET = 6'd32;
    localparam logic [FRAC_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [CNT_W-1:0]  CNT_LAST  = 4'd9;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef logic [CH_W-1:0] t_chan;
    typedef t_chan [NUM_CH-1:0] t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_ADDR,
        ST_RUN,
        ST_FIN
    } t_state;

endpackage

>>> rtl/trilinear_grid_interpolator_core.sv
// Trilinear interpolator over a cubic grid of six-channel entries held in one
// synchronous memory. A write word stores one entry and gives no result; entries
// outside the MAX_GRID^3 memory are dropped. A sample word is accepted, then the
// base and address states form the base address and the square of the grid size,
// then the run state streams the eight corners out of the memory's single read
// port, one corner per cycle, through a two-stage weight multiply into six
// accumulators, and the finish state loads the saturated result into the output
// register once that register is empty or being read; only then is a new word taken.
// A finished result waits in its output register while the next word is taken.
// The memory is not cleared: an entry must be written before a sample reaches it.
// grid_size is read as 2 below 2 and as MAX_GRID above MAX_GRID.
module trilinear_grid_interpolator_core import tgi_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_req_type,
    input  logic [IDX_W-1:0]          i_entry_index,
    input  logic signed [COORD_W-1:0] i_coord_red,
    input  logic signed [COORD_W-1:0] i_coord_green,
    input  logic signed [COORD_W-1:0] i_coord_blue,
    input  logic [CH_W-1:0]           i_write_ch0,
    input  logic [CH_W-1:0]           i_write_ch1,
    input  logic [CH_W-1:0]           i_write_ch2,
    input  logic [CH_W-1:0]           i_write_ch3,
    input  logic [CH_W-1:0]           i_write_ch4,
    input  logic [CH_W-1:0]           i_write_ch5,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [CH_W-1:0]           o_out_ch0,
    output logic [CH_W-1:0]           o_out_ch1,
    output logic [CH_W-1:0]           o_out_ch2,
    output logic [CH_W-1:0]           o_out_ch3,
    output logic [CH_W-1:0]           o_out_ch4,
    output logic [CH_W-1:0]           o_out_ch5
);

    localparam int SZ_W   = $clog2(MAX_GRID + 1);
    localparam int DEPTH  = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PP_W   = 2 * FRAC_W;
    localparam int WP_W   = PROD_W + FRAC_W;
    localparam int TERM_W = WGT_W + CH_W;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_grid_size;
    logic [SZ_W-1:0]    w_size;
    logic               w_in_acc, w_smp_acc, w_mem_we, w_issue, w_load;
    t_entry             w_wdata, w_rdata;
    logic [SZ_W-1:0]    w_lo_r, w_lo_g, w_lo_b;
    logic [FRAC_W-1:0]  w_fr_r, w_fr_g, w_fr_b;
    logic [ADDR_W-1:0]  r_t, r_sz2, r_base, w_raddr;
    logic [CNT_W-1:0]   r_cnt;
    logic [FRAC_W-1:0]  w_wr, w_wg, w_wb;
    logic [PP_W-1:0]    w_pp;
    logic [WP_W-1:0]    w_wp;
    logic [PROD_W-1:0]  r_p;
    logic [FRAC_W-1:0]  r_wb;
    logic [WGT_W-1:0]   r_w;
    t_entry             r_data;
    logic               r_v1, r_v2;
    logic [TERM_W-1:0]  w_term [NUM_CH];
    logic [ACC_W-1:0]   r_acc [NUM_CH];
    logic [CH_W-1:0]    w_sat [NUM_CH];
    logic [CH_W-1:0]    r_out [NUM_CH];
    logic               r_out_valid;

    // effective grid size
    always_comb begin
        if (r_grid_size < CFG_W'(MIN_GRID)) begin
            w_size = SZ_W'(MIN_GRID);
        end else if (int'(r_grid_size) > MAX_GRID) begin
            w_size = SZ_W'(MAX_GRID);
        end else begin
            w_size = SZ_W'(r_grid_size);
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_grid_size <= i_cfg_data;
        end
    end

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_smp_acc = w_in_acc && (i_req_type == REQ_SAMPLE);
    assign w_mem_we  = w_in_acc && (i_req_type == REQ_WRITE) && (int'(i_entry_index) < DEPTH);
    assign w_wdata   = {i_write_ch5, i_write_ch4, i_write_ch3,
                        i_write_ch2, i_write_ch1, i_write_ch0};

    tgi_axis #(.MAX_GRID(MAX_GRID)) u_axis_r (
        .i_clk(i_clk), .i_en(w_smp_acc), .i_coord(i_coord_red), .i_size(w_size),
        .o_lo(w_lo_r), .o_frac(w_fr_r)
    );
    tgi_axis #(.MAX_GRID(MAX_GRID)) u_axis_g (
        .i_clk(i_clk), .i_en(w_smp_acc), .i_coord(i_coord_green), .i_size(w_size),
        .o_lo(w_lo_g), .o_frac(w_fr_g)
    );
    tgi_axis #(.MAX_GRID(MAX_GRID)) u_axis_b (
        .i_clk(i_clk), .i_en(w_smp_acc), .i_coord(i_coord_blue), .i_size(w_size),
        .o_lo(w_lo_b), .o_frac(w_fr_b)
    );

    tgi_grid_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk(i_clk),
        .i_we(w_mem_we),
        .i_waddr(ADDR_W'(i_entry_index)),
        .i_wdata(w_wdata),
        .i_re(w_issue),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_smp_acc) begin
                    n_state = ST_BASE;
                end
            end
            ST_BASE: n_state = ST_ADDR;
            ST_ADDR: n_state = ST_RUN;
            ST_RUN: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_RUN:  w_issue    = !r_cnt[CNT_W-1];
            ST_FIN:  w_load     = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            if (r_state == ST_ADDR) begin
                r_cnt <= '0;
            end else if (r_state == ST_RUN) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // corner bits of the count: bit 0 red, bit 1 green, bit 2 blue
    assign w_raddr = r_base + ADDR_W'(r_cnt[0])
                   + (r_cnt[1] ? ADDR_W'(w_size) : '0)
                   + (r_cnt[2] ? r_sz2 : '0);

    assign w_wr = r_cnt[0] ? w_fr_r : ONE_Q16 - w_fr_r;
    assign w_wg = r_cnt[1] ? w_fr_g : ONE_Q16 - w_fr_g;
    assign w_wb = r_cnt[2] ? w_fr_b : ONE_Q16 - w_fr_b;
    assign w_pp = PP_W'(w_wr) * PP_W'(w_wg);
    assign w_wp = WP_W'(r_p) * WP_W'(r_wb);

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            w_term[ch] = TERM_W'(r_w) * TERM_W'(r_data[ch]);
            if (|r_acc[ch][ACC_W-1:Q_SHIFT+CH_W]) begin
                w_sat[ch] = '1;
            end else begin
                w_sat[ch] = r_acc[ch][Q_SHIFT+CH_W-1:Q_SHIFT];
            end
        end
    end

    // address setup and the corner pipeline
    always_ff @(posedge i_clk) begin
        if (r_state == ST_BASE) begin
            r_t   <= ADDR_W'(w_lo_b) * ADDR_W'(w_size) + ADDR_W'(w_lo_g);
            r_sz2 <= ADDR_W'(w_size) * ADDR_W'(w_size);
        end
        if (r_state == ST_ADDR) begin
            r_base <= r_t * ADDR_W'(w_size) + ADDR_W'(w_lo_r);
        end
        if (w_issue) begin
            r_p  <= w_pp[PP_W-1:Q_SHIFT];
            r_wb <= w_wb;
        end
        if (r_v1) begin
            r_w    <= w_wp[Q_SHIFT+WGT_W-1:Q_SHIFT];
            r_data <= w_rdata;
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (r_state == ST_ADDR) begin
                r_acc[ch] <= '0;
            end else if (r_v2) begin
                r_acc[ch] <= r_acc[ch] + ACC_W'(w_term[ch]);
            end
        end
        if (w_load) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_out[ch] <= w_sat[ch];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_ch0   = r_out[0];
    assign o_out_ch1   = r_out[1];
    assign o_out_ch2   = r_out[2];
    assign o_out_ch3   = r_out[3];
    assign o_out_ch4   = r_out[4];
    assign o_out_ch5   = r_out[5];

    ap_drained_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (!r_v1 && !r_v2))
        else $error("corner pipeline not drained when result is loaded");

    ap_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_cnt == CNT_LAST) |-> (r_v2 && !r_v1))
        else $error("last corner not at accumulate stage at end of run");

    ap_read_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> $past(r_state) == ST_RUN)
        else $error("memory read data flagged outside the corner run");

    ap_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_FIN)
        else $error("result raised without a finished sample");

endmodule

>>> rtl/tgi_axis.sv
// one axis: clamp of the coordinate, scale by grid size minus one, lower corner and fraction
module tgi_axis import tgi_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF,
    localparam int SZ_W    = $clog2(MAX_GRID + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [COORD_W-1:0] i_coord,
    input  logic [SZ_W-1:0]           i_size,
    output logic [SZ_W-1:0]           o_lo,
    output logic [FRAC_W-1:0]         o_frac
);

    localparam int S_W = FRAC_W + SZ_W;

    logic [FRAC_W-1:0] w_clamp;
    logic [S_W-1:0]    w_scaled;
    logic [SZ_W:0]     w_int;
    logic [SZ_W-1:0]   w_cap;
    logic [SZ_W-1:0]   w_lo;
    logic [S_W-1:0]    w_frac_full;
    logic [SZ_W-1:0]   r_lo;
    logic [FRAC_W-1:0] r_frac;

    always_comb begin
        if (i_coord < 0) begin
            w_clamp = '0;
        end else if (i_coord > $signed({1'b0, ONE_Q16})) begin
            w_clamp = ONE_Q16;
        end else begin
            w_clamp = i_coord[FRAC_W-1:0];
        end
    end

    assign w_scaled    = S_W'(w_clamp) * S_W'(i_size - SZ_W'(1));
    assign w_int       = w_scaled[S_W-1:Q_SHIFT];
    assign w_cap       = i_size - SZ_W'(MIN_GRID);
    // lower corner never passes size-2 so the upper corner stays inside the grid
    assign w_lo        = (w_int > {1'b0, w_cap}) ? w_cap : w_int[SZ_W-1:0];
    assign w_frac_full = w_scaled - S_W'({w_lo, {Q_SHIFT{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo   <= w_lo;
            r_frac <= w_frac_full[FRAC_W-1:0];
        end
    end

    assign o_lo   = r_lo;
    assign o_frac = r_frac;

endmodule

>>> rtl/tgi_grid_mem.sv
// grid entry memory: one write port, one registered read port
module tgi_grid_mem import tgi_pkg::*; #(
    parameter int DEPTH    = MAX_GRID_DEF * MAX_GRID_DEF * MAX_GRID_DEF,
    localparam int ADDR_W  = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_entry            o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
